// File: hdl/cat_pkg.sv
package cat_pkg;

  localparam int MAX_PACKETS = 1024;
  localparam int IDX_W = 16;
  localparam int HDR_W = 32;
  localparam int KIND_W = 2;

  localparam int WORD_W = 32;
  localparam int BIT_W = $clog2(WORD_W);
  localparam int ROWS = (MAX_PACKETS + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PTR_W = $clog2(MAX_PACKETS + 1);
  localparam int RUN_W = BIT_W + 1;

  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(MAX_PACKETS);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(MAX_PACKETS);

  typedef enum logic [KIND_W-1:0] {
    KIND_CUM   = 2'd0,
    KIND_DUP   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } map_req_t;

  // length of the run of set bits starting at pos, up to the top of the word
  function automatic logic [RUN_W-1:0] ones_run(input logic [WORD_W-1:0] w,
                                                input logic [BIT_W-1:0] pos);
    logic [WORD_W-1:0] s;
    logic [RUN_W-1:0]  n;
    s = w >> pos;
    n = RUN_W'(WORD_W) - RUN_W'(pos);
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!s[i]) begin
        n = RUN_W'(i);
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/cat_if.sv
interface cat_in_if;
  import cat_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] packet_index;
  logic [HDR_W-1:0] header_value;

  modport source (output valid, output packet_index, output header_value, input ready);
  modport sink (input valid, input packet_index, input header_value, output ready);
endinterface

interface cat_out_if;
  import cat_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  ack_number;
  logic [HDR_W-1:0]  tail_bytes;
  logic              last;

  modport source (output valid, output kind, output ack_number, output tail_bytes,
                  output last, input ready);
  modport sink (input valid, input kind, input ack_number, input tail_bytes,
                input last, output ready);
endinterface

// File: hdl/cat_map_ram.sv
module cat_map_ram (
  input  logic                            clk,
  input  logic                            rst,
  input  cat_pkg::map_req_t               req,
  output logic [cat_pkg::WORD_W-1:0]      rdata
);
  import cat_pkg::*;

  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_valid;
  logic [WORD_W-1:0] rd_word;
  logic              rd_ok;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr];
    end
  end

  // a row never written reads as all clear
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= row_valid[req.rd_addr];
      end
    end
  end

  assign rdata = rd_ok ? rd_word : '0;

endmodule

// File: hdl/cumulative_ack_receive_tracker.sv
// channel  dir  payload                                  role
// pkt      in   packet_index, header_value               arriving data packet
// res      out  kind, ack_number, tail_bytes, last       ack / completion / error
//
// one packet at a time. a repeat after completion or an out-of-range index is
// answered at look-up, a duplicate passes on to finish, a new packet sets its bit,
// then reads and checks each bitmap word the next-expected pointer crosses (none
// when the count is at or below it); bitmap ram read-modify-write sets the pace.
// rst is synchronous; per-row valid bits clear the bitmap at once, no sweep.
// a stalled result register holds the sequencer but the last result of one
// packet may wait while the next packet is taken.
module cumulative_ack_receive_tracker (
  input  logic clk,
  input  logic rst,
  cat_in_if.sink   pkt,
  cat_out_if.source res
);
  import cat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_LOOK     = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CHK = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [PTR_W-1:0] ptr, ptr_next;
  logic [PTR_W-1:0] total;
  logic [HDR_W-1:0] tail_len;
  logic             complete;
  logic [IDX_W-1:0] idx;
  logic [HDR_W-1:0] hdr;

  logic              out_valid;
  kind_t             out_kind;
  logic [IDX_W-1:0]  out_ack;
  logic [HDR_W-1:0]  out_tail;
  logic              out_last;

  map_req_t          map_req;
  logic [WORD_W-1:0] rdata;

  logic              slot_free;
  logic              emit;
  kind_t             e_kind;
  logic [IDX_W-1:0]  e_ack;
  logic [HDR_W-1:0]  e_tail;
  logic              e_last;
  logic              take_hdr;
  logic              set_done;
  logic              out_of_range;
  logic [RUN_W-1:0]  run;
  logic [PTR_W-1:0]  reach;
  logic              word_end;

  cat_map_ram u_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .rdata (rdata)
  );

  assign slot_free = !out_valid || res.ready;
  assign out_of_range = {1'b0, idx} >= IDX_LIMIT;

  assign run = ones_run(rdata, ptr[BIT_W-1:0]);
  assign reach = ptr + PTR_W'(run);
  assign word_end = run == (RUN_W'(WORD_W) - RUN_W'(ptr[BIT_W-1:0]));

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    map_req = '0;
    emit = 1'b0;
    e_kind = KIND_CUM;
    e_ack = '0;
    e_tail = '0;
    e_last = 1'b1;
    take_hdr = 1'b0;
    set_done = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pkt.valid) begin
          map_req.rd_en = 1'b1;
          map_req.rd_addr = pkt.packet_index[BIT_W +: ROW_W];
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (complete) begin
          if (slot_free) begin
            emit = 1'b1;
            e_kind = KIND_DONE;
            e_tail = tail_len;
            state_next = S_IDLE;
          end
        end else if (out_of_range) begin
          if (slot_free) begin
            emit = 1'b1;
            e_kind = KIND_RANGE;
            e_ack = idx;
            state_next = S_IDLE;
          end
        end else if (rdata[idx[BIT_W-1:0]]) begin
          if (slot_free) begin
            emit = 1'b1;
            e_kind = KIND_DUP;
            e_ack = idx;
            // last only when nothing follows it
            e_last = (ptr == '0) && (ptr < total);
            state_next = S_FINISH;
          end
        end else begin
          map_req.wr_en = 1'b1;
          map_req.wr_addr = idx[BIT_W +: ROW_W];
          map_req.wr_data = rdata | (WORD_W'(1) << idx[BIT_W-1:0]);
          take_hdr = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (ptr >= total) begin
          state_next = S_FINISH;
        end else begin
          map_req.rd_en = 1'b1;
          map_req.rd_addr = ptr[BIT_W +: ROW_W];
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (reach >= total) begin
          ptr_next = total;
          state_next = S_FINISH;
        end else begin
          ptr_next = reach;
          state_next = word_end ? S_SCAN_RD : S_FINISH;
        end
      end
      S_FINISH: begin
        if (ptr >= total) begin
          if (slot_free) begin
            emit = 1'b1;
            e_kind = KIND_DONE;
            e_tail = tail_len;
            set_done = 1'b1;
            state_next = S_IDLE;
          end
        end else if (ptr != '0) begin
          if (slot_free) begin
            emit = 1'b1;
            e_kind = KIND_CUM;
            e_ack = IDX_W'(ptr - PTR_W'(1));
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr <= '0;
      total <= PTR_MAX;
      tail_len <= '0;
      complete <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      if (set_done) begin
        complete <= 1'b1;
      end
      if (take_hdr && idx == IDX_W'(0)) begin
        tail_len <= hdr;
      end
      if (take_hdr && idx == IDX_W'(1)) begin
        total <= (hdr > HDR_W'(MAX_PACKETS)) ? PTR_MAX : hdr[PTR_W-1:0];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pkt.valid) begin
      idx <= pkt.packet_index;
      hdr <= pkt.header_value;
    end
    if (emit) begin
      out_kind <= e_kind;
      out_ack <= e_ack;
      out_tail <= e_tail;
      out_last <= e_last;
    end
  end

  assign pkt.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.kind = out_kind;
  assign res.ack_number = out_ack;
  assign res.tail_bytes = out_tail;
  assign res.last = out_last;

  a_done_means_reached: assert property (@(posedge clk) disable iff (rst)
    complete |-> ptr >= total)
    else $error("completion flagged with pointer below total");

  a_ptr_bounded: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_MAX)
    else $error("next-expected pointer beyond capacity");

  a_check_follows_read: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_CHK |-> $past(state) == S_SCAN_RD)
    else $error("bitmap word checked without a read");

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    pkt.valid && pkt.ready |=> state == S_LOOK)
    else $error("accepted packet not looked up");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready |=> out_valid && $stable(out_ack) && $stable(out_kind))
    else $error("pending result overwritten");

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cat_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  ack;
    logic [HDR_W-1:0]  tail;
    logic              last;
  } ack_res_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [HDR_W-1:0] hdr;
    int               n_typed;   // -1: take the tracker model
    ack_res_t         t0;
    ack_res_t         t1;
  } dir_row_t;

  localparam int N_RANDOM = 1880;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;

  cat_in_if  pkt_if ();
  cat_out_if res_if ();

  cumulative_ack_receive_tracker uut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_if.sink),
    .res (res_if.source)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver side tracking model
  bit       rx_map [MAX_PACKETS];
  int       next_ptr;
  int       total_cnt;
  logic [HDR_W-1:0] tail_len;
  bit       xfer_done;

  ack_res_t pending_acks [$];
  dir_row_t dir_tab [$];
  int       fresh_idx [$];
  int       seen_idx [$];

  int  errors;
  int  stall_left;
  bit  quiet;
  int  n_pkts;
  int  n_range;
  int  n_pauses;
  int  kind_cnt [4];

  function automatic ack_res_t mk_res(kind_t k, logic [IDX_W-1:0] a, logic [HDR_W-1:0] t,
                                      logic l);
    ack_res_t r;
    r.kind = k;
    r.ack  = a;
    r.tail = t;
    r.last = l;
    return r;
  endfunction

  function automatic void add_row(logic [IDX_W-1:0] idx, logic [HDR_W-1:0] hdr, int n,
                                  ack_res_t t0, ack_res_t t1);
    dir_row_t row;
    row.idx = idx;
    row.hdr = hdr;
    row.n_typed = n;
    row.t0 = t0;
    row.t1 = t1;
    dir_tab.push_back(row);
  endfunction

  function automatic void track_packet(input logic [IDX_W-1:0] idx,
                                       input logic [HDR_W-1:0] hdr,
                                       output int n, output ack_res_t r0,
                                       output ack_res_t r1);
    ack_res_t rr [2];
    int       i;
    i = int'(idx);
    n = 0;
    rr[0] = '0;
    rr[1] = '0;
    if (xfer_done) begin
      rr[0] = mk_res(KIND_DONE, '0, tail_len, 1'b1);
      n = 1;
    end else if (i >= MAX_PACKETS) begin
      rr[0] = mk_res(KIND_RANGE, idx, '0, 1'b1);
      n = 1;
    end else begin
      if (rx_map[i]) begin
        rr[0] = mk_res(KIND_DUP, idx, '0, 1'b0);
        n = 1;
      end else begin
        rx_map[i] = 1'b1;
        if (i == 0) begin
          tail_len = hdr;
        end else if (i == 1) begin
          total_cnt = (hdr > HDR_W'(MAX_PACKETS)) ? MAX_PACKETS : int'(hdr);
        end
        while (next_ptr < total_cnt && next_ptr < MAX_PACKETS && rx_map[next_ptr]) begin
          next_ptr++;
        end
      end
      if (next_ptr >= total_cnt) begin
        xfer_done = 1'b1;
        rr[n] = mk_res(KIND_DONE, '0, tail_len, 1'b1);
        n++;
      end else if (next_ptr != 0) begin
        rr[n] = mk_res(KIND_CUM, IDX_W'(next_ptr - 1), '0, 1'b1);
        n++;
      end else if (n > 0) begin
        rr[n-1].last = 1'b1;
      end
    end
    r0 = rr[0];
    r1 = rr[1];
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // one request on the packet channel, with an optional idle burst in front
  task automatic push_packet(logic [IDX_W-1:0] idx, logic [HDR_W-1:0] hdr, int n_typed,
                             ack_res_t t0, ack_res_t t1);
    ack_res_t p0;
    ack_res_t p1;
    int       n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      pkt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    pkt_if.valid        <= 1'b1;
    pkt_if.packet_index <= idx;
    pkt_if.header_value <= hdr;
    do @(posedge clk); while (!pkt_if.ready);
    track_packet(idx, hdr, n, p0, p1);
    if (n_typed >= 0) begin
      n = n_typed;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) pending_acks.push_back(p0);
    if (n > 1) pending_acks.push_back(p1);
    n_pkts++;
    if (int'(idx) >= MAX_PACKETS) n_range++;
  endtask

  task automatic drain_all();
    pkt_if.valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_pauses++;
  endtask

  // result side: random back-pressure bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      res_if.ready <= 1'b0;
      stall_left = $urandom_range(1, 5) - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ack_res_t got;
    ack_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = mk_res(kind_t'(res_if.kind), res_if.ack_number, res_if.tail_bytes, res_if.last);
      kind_cnt[res_if.kind]++;
      if (pending_acks.size() == 0) begin
        flag_error($sformatf("result with none expected: kind %0d ack %0d tail %h last %0d",
                             got.kind, got.ack, got.tail, got.last));
      end else begin
        want = pending_acks.pop_front();
        if (got.kind !== want.kind || got.ack !== want.ack || got.tail !== want.tail ||
            got.last !== want.last) begin
          flag_error($sformatf({"expected kind %0d ack %0d tail %h last %0d, ",
                                "got kind %0d ack %0d tail %h last %0d"},
                               want.kind, want.ack, want.tail, want.last,
                               got.kind, got.ack, got.tail, got.last));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    ack_res_t none;
    int       idx;
    int       k;
    int       r;
    logic [HDR_W-1:0] hdr;

    none = '0;
    errors = 0;
    quiet = 1'b0;
    n_pkts = 0;
    n_range = 0;
    n_pauses = 0;
    foreach (kind_cnt[j]) kind_cnt[j] = 0;
    foreach (rx_map[j]) rx_map[j] = 1'b0;
    next_ptr = 0;
    total_cnt = MAX_PACKETS;
    tail_len = '0;
    xfer_done = 1'b0;

    rst <= 1'b1;
    pkt_if.valid <= 1'b0;
    pkt_if.packet_index <= '0;
    pkt_if.header_value <= '0;

    // nothing to acknowledge while packet 0 is missing
    add_row(16'd5, $urandom, 0, none, none);
    add_row(16'hFFFF, 32'hFFFF_FFFF, 1, mk_res(KIND_RANGE, 16'hFFFF, '0, 1'b1), none);
    add_row(16'(MAX_PACKETS), 32'h0, 1, mk_res(KIND_RANGE, 16'(MAX_PACKETS), '0, 1'b1), none);
    add_row(16'(MAX_PACKETS - 1), 32'hFFFF_FFFF, 0, none, none);
    // duplicate with pointer still at zero carries last itself
    add_row(16'd5, 32'h0, 1, mk_res(KIND_DUP, 16'd5, '0, 1'b1), none);
    add_row(16'd0, $urandom, 1, mk_res(KIND_CUM, 16'd0, '0, 1'b1), none);
    add_row(16'd0, 32'h0, 2, mk_res(KIND_DUP, 16'd0, '0, 1'b0),
            mk_res(KIND_CUM, 16'd0, '0, 1'b1));
    add_row(16'd2, $urandom, -1, none, none);
    // oversized count saturates at capacity
    add_row(16'd1, 32'hFFFF_FFFF, -1, none, none);
    add_row(16'd1, 32'h0, -1, none, none);
    add_row(16'd3, $urandom, -1, none, none);
    add_row(16'd4, $urandom, -1, none, none);
    add_row(16'd31, $urandom, -1, none, none);
    add_row(16'd33, $urandom, -1, none, none);
    add_row(16'd32, $urandom, -1, none, none);
    add_row(16'h8000, $urandom, 1, mk_res(KIND_RANGE, 16'h8000, '0, 1'b1), none);
    add_row(16'(MAX_PACKETS - 2), $urandom, -1, none, none);
    add_row(16'(MAX_PACKETS - 1), $urandom, -1, none, none);
    add_row(16'd64, $urandom, -1, none, none);
    add_row(16'd6, $urandom, -1, none, none);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[j]) begin
      push_packet(dir_tab[j].idx, dir_tab[j].hdr, dir_tab[j].n_typed, dir_tab[j].t0,
                  dir_tab[j].t1);
    end
    drain_all();

    for (int j = 0; j < MAX_PACKETS; j++) begin
      if (rx_map[j]) seen_idx.push_back(j);
      else fresh_idx.push_back(j);
    end

    // mostly fresh packets out of a small reorder window, some far jumps,
    // duplicates and out-of-range noise; completion comes late in the run
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 1100 && i < 1250) || (i >= N_RANDOM - 200);
      if (i == 900) drain_all();
      r = $urandom_range(0, 99);
      hdr = $urandom;
      if (r < 8) begin
        idx = (r == 0) ? 16'hFFFF : $urandom_range(MAX_PACKETS, 16'hFFFF);
      end else if (r < 38 || fresh_idx.size() == 0) begin
        if ($urandom_range(0, 1) == 0 && seen_idx.size() > 16) begin
          k = $urandom_range(seen_idx.size() - 16, seen_idx.size() - 1);
        end else begin
          k = $urandom_range(0, seen_idx.size() - 1);
        end
        idx = seen_idx[k];
      end else begin
        if ($urandom_range(0, 24) == 0) k = $urandom_range(0, fresh_idx.size() - 1);
        else k = $urandom_range(0, (fresh_idx.size() < 8) ? fresh_idx.size() - 1 : 7);
        idx = fresh_idx[k];
        fresh_idx.delete(k);
        seen_idx.push_back(idx);
      end
      push_packet(16'(idx), hdr, -1, none, none);
    end

    pkt_if.valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d packets (%0d out of range, %0d drain pauses), transfer %s",
             n_pkts, n_range, n_pauses, xfer_done ? "completed" : "still open");
    $display("results: %0d cumulative, %0d duplicate, %0d completion, %0d range, %0d errors",
             kind_cnt[KIND_CUM], kind_cnt[KIND_DUP], kind_cnt[KIND_DONE],
             kind_cnt[KIND_RANGE], errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
